// ===== src/gs3_pkg.sv =====
// Shared constants, codes and types of the iterative 3x3 solver.
package gs3_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DATA_W    = 64;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int IDX_W     = 8;
  localparam int CFG_W     = 32;
  localparam int ITER_W    = 16;
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0] CFG_MODE = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_TOL  = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_MAX  = IDX_W'(2);

  localparam logic [CFG_W-1:0]  TOL_RESET = CFG_W'(4295);
  localparam logic [ITER_W-1:0] MAX_RESET = ITER_W'(1000);

  typedef enum logic [1:0] {
    ST_CONV  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_ZERO  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_COPY,
    OP_NUM_INIT,
    OP_MUL_LOAD,
    OP_TOL_LOAD,
    OP_MUL_STEP,
    OP_NUM_SUB,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_TOL_CHECK,
    OP_INC,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ZCHK,
    S_ITER,
    S_NUMI,
    S_MULS,
    S_MULR,
    S_SUB,
    S_DIVS,
    S_DIVR,
    S_DIVE,
    S_TOLS,
    S_TOLR,
    S_TOLC,
    S_NEXT,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] step;
    stat_t      stat;
  } cmd_t;

  typedef struct packed {
    logic diag_zero;
    logic settled;
    logic limit_hit;
  } sts_t;

endpackage

// ===== src/gs3_req_if.sv =====
// Request channel: one whole 3x3 system.
interface gs3_req_if;
  logic valid;
  logic ready;
  logic signed [63:0] coef_00;
  logic signed [63:0] coef_01;
  logic signed [63:0] coef_02;
  logic signed [63:0] coef_10;
  logic signed [63:0] coef_11;
  logic signed [63:0] coef_12;
  logic signed [63:0] coef_20;
  logic signed [63:0] coef_21;
  logic signed [63:0] coef_22;
  logic signed [63:0] rhs_0;
  logic signed [63:0] rhs_1;
  logic signed [63:0] rhs_2;
  modport source (output valid, coef_00, coef_01, coef_02, coef_10, coef_11, coef_12,
                  coef_20, coef_21, coef_22, rhs_0, rhs_1, rhs_2, input ready);
  modport sink (input valid, coef_00, coef_01, coef_02, coef_10, coef_11, coef_12,
                coef_20, coef_21, coef_22, rhs_0, rhs_1, rhs_2, output ready);
endinterface

// ===== src/gs3_res_if.sv =====
// Result channel: solution, iteration count and status.
interface gs3_res_if;
  logic valid;
  logic ready;
  logic signed [63:0] sol_a;
  logic signed [63:0] sol_b;
  logic signed [63:0] sol_c;
  logic [15:0] iterations_done;
  logic [1:0]  status;
  modport source (output valid, sol_a, sol_b, sol_c, iterations_done, status, input ready);
  modport sink (input valid, sol_a, sol_b, sol_c, iterations_done, status, output ready);
endinterface

// ===== src/gs3_cfg_if.sv =====
// Configuration write channel.
interface gs3_cfg_if;
  logic valid;
  logic ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/iterative_3x3_linear_solver_top.sv =====
// Iterative 3x3 linear solver top level: Gauss-Seidel or Jacobi iteration in Q32.32.
// One request at a time. Each iteration runs three rows, each of two products on
// the shared 32x32 multiplier and a 128-step restoring division at one quotient
// bit per cycle, then three tolerance products. A system with a zero diagonal
// entry returns without iterating. The result sits in an output register, so
// the next request is taken while it waits.
module iterative_3x3_linear_solver_top (
  input logic clk,
  input logic rst,
  gs3_req_if.sink   req,
  gs3_res_if.source res,
  gs3_cfg_if.sink   cfg
);
  import gs3_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] sys_in [12];
  logic [DATA_W-1:0] sol [3];
  logic [ITER_W-1:0] iters;
  logic [1:0]        status;

  assign sys_in[0]  = req.coef_00;
  assign sys_in[1]  = req.coef_01;
  assign sys_in[2]  = req.coef_02;
  assign sys_in[3]  = req.coef_10;
  assign sys_in[4]  = req.coef_11;
  assign sys_in[5]  = req.coef_12;
  assign sys_in[6]  = req.coef_20;
  assign sys_in[7]  = req.coef_21;
  assign sys_in[8]  = req.coef_22;
  assign sys_in[9]  = req.rhs_0;
  assign sys_in[10] = req.rhs_1;
  assign sys_in[11] = req.rhs_2;

  assign cfg.ready = 1'b1;

  gs3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gs3_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .sys_in   (sys_in),
    .cfg_we   (cfg.valid),
    .cfg_idx  (cfg.index),
    .cfg_data (cfg.data),
    .sol      (sol),
    .iters    (iters),
    .status   (status)
  );

  assign res.sol_a           = sol[0];
  assign res.sol_b           = sol[1];
  assign res.sol_c           = sol[2];
  assign res.iterations_done = iters;
  assign res.status          = status;

endmodule

// ===== src/gs3_dp.sv =====
// Solver datapath: system store, estimates, shared multiplier and divider.
module gs3_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  gs3_pkg::cmd_t              cmd,
  output gs3_pkg::sts_t              sts,
  input  logic [gs3_pkg::DATA_W-1:0] sys_in [12],
  input  logic                       cfg_we,
  input  logic [gs3_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [gs3_pkg::CFG_W-1:0]  cfg_data,
  output logic [gs3_pkg::DATA_W-1:0] sol [3],
  output logic [gs3_pkg::ITER_W-1:0] iters,
  output logic [1:0]                 status
);
  import gs3_pkg::*;

  localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int HALF = DATA_W / 2;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat(input logic neg, input logic [PROD_W-1:0] m);
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] v;
    lim = neg ? NEG_MAX : POS_MAX;
    v = ((|m[PROD_W-1:DATA_W]) || (m[DATA_W-1:0] > lim)) ? lim : m[DATA_W-1:0];
    return neg ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a - b;
    if (((a ^ b) & (a ^ s)) >> (DATA_W-1) != '0)
      return a[DATA_W-1] ? NEG_MAX : POS_MAX;
    return s;
  endfunction

  logic [DATA_W-1:0] coef [12];
  logic [DATA_W-1:0] est [3];
  logic [DATA_W-1:0] prev [3];
  logic [ITER_W-1:0] iter;
  logic              mode;
  logic [CFG_W-1:0]  tol;
  logic [ITER_W-1:0] iter_limit;
  logic              settle;

  logic [DATA_W-1:0] num;
  logic [DATA_W-1:0] ma, mb;
  logic              mneg;
  logic [PROD_W-1:0] acc;

  logic [DATA_W-1:0] dd;
  logic [PROD_W-1:0] dvd;
  logic [PROD_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic              dneg;

  logic [3:0]        cidx;
  logic [3:0]        didx;
  logic [DATA_W-1:0] src_val;
  logic [HALF-1:0]   pa, pb;
  logic [DATA_W-1:0] pp;
  logic [PROD_W-1:0] pp_sh;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   tdiff;
  logic              ge;
  logic [DATA_W-1:0] nv, ov, diff;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] prod_fx;

  assign cidx    = 4'({2'b00, cmd.row} * 4'd3 + {2'b00, cmd.col});
  assign didx    = {cmd.row, 2'b00};
  assign src_val = mode ? prev[cmd.col] : est[cmd.col];

  // 32x32 partial products, one per step
  assign pa = cmd.step[1] ? ma[DATA_W-1:HALF] : ma[HALF-1:0];
  assign pb = cmd.step[0] ? mb[DATA_W-1:HALF] : mb[HALF-1:0];
  assign pp = pa * pb;
  always_comb begin
    case (cmd.step)
      2'd0:    pp_sh = {{DATA_W{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {DATA_W{1'b0}}};
      default: pp_sh = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
    endcase
  end

  assign prod_fx = acc >> FRAC_BITS;

  // restoring division step, carry folded into the trial word
  assign trial = {rem, dvd[PROD_W-1]};
  assign ge    = trial >= {1'b0, dd};
  assign tdiff = trial - {1'b0, dd};

  assign nv   = est[cmd.row];
  assign ov   = prev[cmd.row];
  assign diff = ({~nv[DATA_W-1], nv[DATA_W-2:0]} >= {~ov[DATA_W-1], ov[DATA_W-2:0]}) ?
                (nv - ov) : (ov - nv);
  assign lhs  = {{HALF{1'b0}}, diff, {HALF{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      tol        <= TOL_RESET;
      iter_limit <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE: mode       <= cfg_data[0];
        CFG_TOL:  tol        <= cfg_data;
        CFG_MAX:  iter_limit <= cfg_data[ITER_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        coef <= sys_in;
        for (int k = 0; k < 3; k++) begin
          est[k]  <= '0;
          prev[k] <= '0;
        end
        iter <= '0;
      end
      OP_COPY: begin
        prev   <= est;
        settle <= 1'b1;
      end
      OP_NUM_INIT: num <= coef[4'(9 + cmd.row)];
      OP_MUL_LOAD: begin
        ma   <= mag(coef[cidx]);
        mb   <= mag(src_val);
        mneg <= coef[cidx][DATA_W-1] ^ src_val[DATA_W-1];
        acc  <= '0;
      end
      OP_TOL_LOAD: begin
        ma  <= {{(DATA_W-CFG_W){1'b0}}, tol};
        mb  <= mag(est[cmd.row]);
        acc <= '0;
      end
      OP_MUL_STEP: acc <= acc + pp_sh;
      OP_NUM_SUB:  num <= sat_sub(num, sat(mneg, prod_fx));
      OP_DIV_LOAD: begin
        dd   <= mag(coef[didx]);
        dvd  <= {{DATA_W{1'b0}}, mag(num)} << FRAC_BITS;
        quo  <= '0;
        rem  <= '0;
        dneg <= num[DATA_W-1] ^ coef[didx][DATA_W-1];
      end
      OP_DIV_STEP: begin
        rem <= ge ? tdiff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo <= {quo[PROD_W-2:0], ge};
        dvd <= {dvd[PROD_W-2:0], 1'b0};
      end
      OP_DIV_END:   est[cmd.row] <= sat(dneg, quo);
      OP_TOL_CHECK: settle <= settle & (lhs <= acc);
      OP_INC:       iter <= iter + 1'b1;
      OP_OUT: begin
        sol    <= est;
        iters  <= iter;
        status <= cmd.stat;
      end
      default: ;
    endcase
  end

  assign sts.diag_zero = (coef[0] == '0) || (coef[4] == '0) || (coef[8] == '0);
  assign sts.settled   = settle;
  assign sts.limit_hit = iter >= iter_limit;

endmodule

// ===== src/gs3_ctrl.sv =====
// Solver sequencer: walks rows, products, division steps and the convergence test.
module gs3_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_ready,
  input  gs3_pkg::sts_t sts,
  output gs3_pkg::cmd_t cmd
);
  import gs3_pkg::*;

  state_t           state, state_next;
  logic [1:0]       row, row_next;
  logic [1:0]       col, col_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  stat_t            stat, stat_next;
  logic             res_load;
  logic [2:0]       col_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      col       <= '0;
      cnt       <= '0;
      stat      <= ST_CONV;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      cnt   <= cnt_next;
      stat  <= stat_next;
      if (res_load)
        res_valid <= 1'b1;
      else if (res_ready)
        res_valid <= 1'b0;
    end
  end

  // next column that is not the diagonal
  always_comb begin
    col_inc = {1'b0, col} + 3'd1;
    if (col_inc[1:0] == row && !col_inc[2])
      col_inc = col_inc + 3'd1;
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    cnt_next   = cnt;
    stat_next  = stat;
    res_load   = 1'b0;
    req_ready  = 1'b0;
    cmd        = '{op: OP_NOP, row: row, col: col, step: cnt[1:0], stat: stat};
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (sts.diag_zero) begin
          stat_next  = ST_ZERO;
          state_next = S_DONE;
        end else begin
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        cmd.op     = OP_COPY;
        row_next   = '0;
        state_next = S_NUMI;
      end
      S_NUMI: begin
        cmd.op     = OP_NUM_INIT;
        col_next   = (row == 2'd0) ? 2'd1 : 2'd0;
        state_next = S_MULS;
      end
      S_MULS: begin
        cmd.op     = OP_MUL_LOAD;
        cnt_next   = '0;
        state_next = S_MULR;
      end
      S_MULR, S_TOLR: begin
        cmd.op   = OP_MUL_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt[1:0] == 2'(MUL_STEPS - 1))
          state_next = (state == S_MULR) ? S_SUB : S_TOLC;
      end
      S_SUB: begin
        cmd.op = OP_NUM_SUB;
        if (col_inc[2] || col_inc[1:0] == 2'd3) begin
          state_next = S_DIVS;
        end else begin
          col_next   = col_inc[1:0];
          state_next = S_MULS;
        end
      end
      S_DIVS: begin
        cmd.op     = OP_DIV_LOAD;
        cnt_next   = '0;
        state_next = S_DIVR;
      end
      S_DIVR: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1))
          state_next = S_DIVE;
      end
      S_DIVE: begin
        cmd.op = OP_DIV_END;
        if (row == 2'd2) begin
          row_next   = '0;
          state_next = S_TOLS;
        end else begin
          row_next   = row + 1'b1;
          state_next = S_NUMI;
        end
      end
      S_TOLS: begin
        cmd.op     = OP_TOL_LOAD;
        cnt_next   = '0;
        state_next = S_TOLR;
      end
      S_TOLC: begin
        cmd.op = OP_TOL_CHECK;
        if (row == 2'd2) begin
          state_next = S_NEXT;
        end else begin
          row_next   = row + 1'b1;
          state_next = S_TOLS;
        end
      end
      S_NEXT: begin
        cmd.op     = OP_INC;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.settled) begin
          stat_next  = ST_CONV;
          state_next = S_DONE;
        end else if (sts.limit_hit) begin
          stat_next  = ST_LIMIT;
          state_next = S_DONE;
        end else begin
          state_next = S_ITER;
        end
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!res_valid || res_ready) begin
          cmd.op     = OP_OUT;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_to_zchk: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_ZCHK))
    else $error("accepted request did not start the diagonal check");
  a_no_diag_product: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULS) |-> (col != row))
    else $error("product issued on the diagonal column");
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || res_ready))
    else $error("result overwritten before it was taken");
  a_mul_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB || state == S_TOLC) |-> ($past(cnt[1:0]) == 2'(MUL_STEPS - 1)))
    else $error("product finished with missing partial products");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the iterative 3x3 solver: directed table, then random systems.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gs3_pkg::*;

  localparam logic [63:0] ONE  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [11:0][63:0] v; // c00..c22 by row, then rhs 0..2
  } sys_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [15:0] iters;
    stat_t       st;
  } sol_t;

  typedef struct {
    bit          cfg_row;
    bit          mode;
    logic [31:0] tol;
    logic [15:0] maxi;
    sys_t        sys;
    bit          typed;
    sol_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  gs3_req_if req_ch();
  gs3_res_if res_ch();
  gs3_cfg_if cfg_ch();

  iterative_3x3_linear_solver_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the configuration registers
  bit          mode_r = 1'b0;
  logic [31:0] tol_r  = TOL_RESET;
  logic [15:0] max_r  = MAX_RESET;

  sol_t     sol_q[$];
  dir_row_t dir_tab[$];
  int       fails = 0;
  int       cycles = 0;
  int       send_idle = 0;
  int       stall_pct = 0;
  logic     hold_tog;
  logic     hold_seen;
  int       hold_left;

  // ---------------- solver arithmetic ----------------
  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sat_wide(bit neg, logic [127:0] m);
    logic [63:0] lim;
    logic [63:0] v;
    lim = neg ? MINV : MAXV;
    v = (m > {64'd0, lim}) ? lim : m[63:0];
    return neg ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    logic [63:0] t;
    s = a - b;
    t = (a ^ b) & (a ^ s);
    if (t[63]) return a[63] ? MINV : MAXV;
    return s;
  endfunction

  function automatic logic [63:0] mul_fx(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, mag64(a)} * {64'd0, mag64(b)}) >> FRAC_BITS;
    return sat_wide(a[63] ^ b[63], p);
  endfunction

  function automatic logic [63:0] div_fx(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, mag64(num)} << FRAC_BITS) / {64'd0, mag64(den)};
    return sat_wide(num[63] ^ den[63], q);
  endfunction

  function automatic bit is_settled(logic [63:0] nv, logic [63:0] ov);
    logic [63:0]  diff;
    logic [127:0] lhs;
    logic [127:0] rhs;
    diff = ($signed(nv) >= $signed(ov)) ? nv - ov : ov - nv;
    lhs = {32'd0, diff, 32'd0};
    rhs = {96'd0, tol_r} * {64'd0, mag64(nv)};
    return lhs <= rhs;
  endfunction

  function automatic sol_t solve_sys(sys_t s);
    logic [63:0] x[3];
    logic [63:0] px[3];
    logic [63:0] src[3];
    logic [63:0] num;
    int   lim;
    int   n;
    bit   done;
    sol_t r;
    lim = (max_r == 16'd0) ? 1 : int'(max_r);
    n = 0;
    done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      x[i] = '0;
      px[i] = '0;
    end
    if (s.v[0] == 64'd0 || s.v[4] == 64'd0 || s.v[8] == 64'd0) begin
      r = '{a: '0, b: '0, c: '0, iters: '0, st: ST_ZERO};
      return r;
    end
    do begin
      px = x;
      for (int i = 0; i < 3; i++) begin
        src = mode_r ? px : x;
        num = s.v[9 + i];
        for (int j = 0; j < 3; j++)
          if (j != i) num = sub_sat(num, mul_fx(s.v[i * 3 + j], src[j]));
        x[i] = div_fx(num, s.v[i * 4]);
      end
      n++;
      done = is_settled(x[0], px[0]) && is_settled(x[1], px[1]) && is_settled(x[2], px[2]);
    end while (!done && n < lim);
    r.a = x[0];
    r.b = x[1];
    r.c = x[2];
    r.iters = 16'(n);
    r.st = done ? ST_CONV : ST_LIMIT;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic sys_t diag_sys(logic [63:0] d0, logic [63:0] d1, logic [63:0] d2,
                                    logic [63:0] b0, logic [63:0] b1, logic [63:0] b2,
                                    logic [63:0] off);
    sys_t s;
    for (int k = 0; k < 9; k++) s.v[k] = off;
    s.v[0] = d0;
    s.v[4] = d1;
    s.v[8] = d2;
    s.v[9] = b0;
    s.v[10] = b1;
    s.v[11] = b2;
    return s;
  endfunction

  function automatic sol_t mk_sol(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                  logic [15:0] n, stat_t st);
    sol_t r;
    r = '{a: a, b: b, c: c, iters: n, st: st};
    return r;
  endfunction

  function automatic void add_cfg(bit m, logic [31:0] t, logic [15:0] mx);
    dir_row_t row;
    row = '{cfg_row: 1'b1, mode: m, tol: t, maxi: mx, sys: '0, typed: 1'b0, want: '0};
    dir_tab.push_back(row);
  endfunction

  function automatic void add_sys(sys_t s, bit typed, sol_t w);
    dir_row_t row;
    row = '{cfg_row: 1'b0, mode: 1'b0, tol: '0, maxi: '0, sys: s, typed: typed, want: w};
    dir_tab.push_back(row);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rnd_sign(logic [63:0] m);
    return $urandom_range(1) ? (64'd0 - m) : m;
  endfunction

  function automatic sys_t rand_sys();
    sys_t s;
    int   k;
    if ($urandom_range(99) < 75) begin
      // diagonally dominant, so the iteration gets somewhere
      for (k = 0; k < 9; k++)
        s.v[k] = rnd_sign({31'd0, 1'($urandom_range(1)), 32'($urandom)});
      for (k = 0; k < 3; k++) begin
        s.v[k * 4] = rnd_sign({32'($urandom_range(4, 20)), 32'($urandom)});
        s.v[9 + k] = rnd_sign(rnd64() >> $urandom_range(16, 40));
      end
    end else begin
      for (k = 0; k < 12; k++) s.v[k] = rnd64();
      if ($urandom_range(3) == 0) s.v[$urandom_range(2) * 4] = '0;
      if ($urandom_range(7) == 0) s.v[$urandom_range(11)] = $urandom_range(1) ? MAXV : MINV;
    end
    return s;
  endfunction

  task automatic write_regs(bit m, logic [31:0] t, logic [15:0] mx);
    logic [7:0]  idx[4];
    logic [31:0] dat[4];
    logic [31:0] junk;
    junk = $urandom;
    idx[0] = CFG_MODE; dat[0] = {junk[31:1], m};
    idx[1] = CFG_TOL;  dat[1] = t;
    idx[2] = CFG_MAX;  dat[2] = {junk[15:0], mx};
    idx[3] = 8'($urandom_range(3, 255)); dat[3] = $urandom; // must be ignored
    for (int k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= dat[k];
      do @(posedge clk); while (!cfg_ch.ready);
      if (idx[k] == CFG_MODE) mode_r = dat[k][0];
      else if (idx[k] == CFG_TOL) tol_r = dat[k];
      else if (idx[k] == CFG_MAX) max_r = dat[k][15:0];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sys(sys_t s, bit typed, sol_t want);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.coef_00 <= s.v[0];
    req_ch.coef_01 <= s.v[1];
    req_ch.coef_02 <= s.v[2];
    req_ch.coef_10 <= s.v[3];
    req_ch.coef_11 <= s.v[4];
    req_ch.coef_12 <= s.v[5];
    req_ch.coef_20 <= s.v[6];
    req_ch.coef_21 <= s.v[7];
    req_ch.coef_22 <= s.v[8];
    req_ch.rhs_0   <= s.v[9];
    req_ch.rhs_1   <= s.v[10];
    req_ch.rhs_2   <= s.v[11];
    do @(posedge clk); while (!req_ch.ready);
    sol_q.push_back(typed ? want : solve_sys(s));
  endtask

  task automatic drain();
    while (sol_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen    <= hold_tog;
      hold_left    <= HOLD_LEN;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sol_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sol_q.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        w = sol_q.pop_front();
        check_field("sol_a", w.a, res_ch.sol_a);
        check_field("sol_b", w.b, res_ch.sol_b);
        check_field("sol_c", w.c, res_ch.sol_c);
        check_field("iterations_done", 64'(w.iters), 64'(res_ch.iterations_done));
        check_field("status", 64'(w.st), 64'(res_ch.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[iterative_3x3_linear_solver_top] ERROR");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    logic [31:0] t;
    sys_t s;
    rst          <= 1'b1;
    hold_tog     <= 1'b0;
    req_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    s = '0;
    {req_ch.coef_00, req_ch.coef_01, req_ch.coef_02, req_ch.coef_10, req_ch.coef_11,
     req_ch.coef_12, req_ch.coef_20, req_ch.coef_21, req_ch.coef_22,
     req_ch.rhs_0, req_ch.rhs_1, req_ch.rhs_2} <= '0;

    // zero diagonal, extremes, Jacobi/Gauss-Seidel, limit of zero, tolerance extremes
    add_sys(diag_sys(0, ONE, ONE, ONE, ONE, ONE, ONE), 1, mk_sol(0, 0, 0, 0, ST_ZERO));
    add_sys(diag_sys(ONE, 0, ONE, MAXV, MINV, ONE, MINV), 1, mk_sol(0, 0, 0, 0, ST_ZERO));
    add_sys(diag_sys(ONE, ONE, 0, ONE, ONE, ONE, MAXV), 1, mk_sol(0, 0, 0, 0, ST_ZERO));
    add_sys(diag_sys(0, 0, 0, 0, 0, 0, 0), 1, mk_sol(0, 0, 0, 0, ST_ZERO));
    add_sys(diag_sys(ONE, ONE, ONE, MAXV, MINV, 0, 0), 1, mk_sol(MAXV, MINV, 0, 2, ST_CONV));
    add_sys(diag_sys(4 * ONE, 64'd0 - 4 * ONE, 4 * ONE, ONE, 64'd0 - 2 * ONE, 3 * ONE, ONE),
            0, '0);
    add_cfg(1, 32'd0, 16'd0);
    add_sys(diag_sys(ONE, ONE, ONE, ONE, 64'hFFFF_FFFF_FFFF_FFFF, MINV, 0), 1,
            mk_sol(ONE, 64'hFFFF_FFFF_FFFF_FFFF, MINV, 1, ST_LIMIT));
    // unknowns that stay at zero settle at once, even with zero tolerance
    add_sys(diag_sys(ONE, ONE, ONE, 0, 0, 0, 0), 1, mk_sol(0, 0, 0, 1, ST_CONV));
    add_cfg(0, 32'hFFFF_FFFF, 16'd3);
    add_sys(diag_sys(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0, '0);
    add_sys(diag_sys(MINV, MINV, MINV, MINV, MINV, MINV, MAXV), 0, '0);
    add_sys(diag_sys(64'd1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, MAXV, MINV, ONE, 0), 0, '0);
    add_sys(diag_sys(MINV, ONE, MAXV, MINV, MAXV, 0, MINV), 0, '0);
    add_sys(diag_sys(64'd0 - ONE, 3 * ONE, 64'd1, ONE, MINV, MAXV, 64'd1), 0, '0);
    add_cfg(0, 32'd0, 16'd2);
    // converges on the last allowed iteration
    add_sys(diag_sys(ONE, ONE, ONE, 5 * ONE, 64'd0 - 7 * ONE, 64'd3, 0), 1,
            mk_sol(5 * ONE, 64'd0 - 7 * ONE, 64'd3, 2, ST_CONV));
    add_cfg(1, TOL_RESET, 16'hFFFF);
    add_sys(diag_sys(ONE, ONE, ONE, 64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210, ONE, 0),
            1, mk_sol(64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210, ONE, 2, ST_CONV));
    add_sys(diag_sys(4 * ONE, 5 * ONE, 64'd0 - 4 * ONE, ONE, 64'd0 - 2 * ONE, 3 * ONE, ONE),
            0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].cfg_row) begin
        req_ch.valid <= 1'b0;
        drain();
        write_regs(dir_tab[k].mode, dir_tab[k].tol, dir_tab[k].maxi);
      end else begin
        send_sys(dir_tab[k].sys, dir_tab[k].typed, dir_tab[k].want);
      end
    end

    idle_tab  = '{0, 68, 0, 31};
    stall_tab = '{0, 0, 68, 31};
    for (int ph = 0; ph < 4; ph++) begin
      req_ch.valid <= 1'b0;
      drain();
      send_idle = idle_tab[ph];
      stall_pct = stall_tab[ph];
      case ($urandom_range(3))
        0: t = 32'd0;
        1: t = 32'hFFFF_FFFF;
        2: t = TOL_RESET;
        default: t = $urandom;
      endcase
      write_regs(1'($urandom_range(1)), t, 16'($urandom_range(1, 8)));
      for (int n = 0; n < 32; n++) begin
        if (ph == 0 && n == 10) begin
          // long hold-off on the result side: output register fills, input stalls
          req_ch.valid <= 1'b0;
          drain();
          hold_tog <= ~hold_tog;
          for (int z = 0; z < 6; z++) begin
            s = rand_sys();
            s.v[4] = '0;
            send_sys(s, 0, '0);
          end
        end
        send_sys(rand_sys(), 0, '0);
      end
    end
    req_ch.valid <= 1'b0;

    while (sol_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("[iterative_3x3_linear_solver_top] OK");
    end else begin
      $display("[iterative_3x3_linear_solver_top] ERROR");
    end
    $finish;
  end

endmodule
